[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the solar term date matcher
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define STDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define STDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/stdm_pkg.sv]
// ----------------------------------------------------------------------------
// stdm_pkg
// widths, constants and tables shared by the solar term date matcher
// ----------------------------------------------------------------------------
package stdm_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TERM_W  = 5;

    localparam int TERM_COUNT = 24;
    localparam int DNUM_W     = 17;    // days since 1900-01-06, last valid date fits
    localparam int YOFS_W     = 8;     // year - 1900
    localparam int PROD_W     = 47;
    localparam int DIFF_W     = 48;

    localparam logic [YEAR_W-1:0] FIRST_YEAR = 14'd1900;
    localparam logic [YEAR_W-1:0] LAST_YEAR  = 14'd2100;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // tropical year in tenths of a millisecond
    localparam logic [38:0] YEAR_TENTHS = 39'd315569259747;
    localparam logic [29:0] DAY_TENTHS  = 30'd864000000;
    // 02:05 in tenths of a ms plus the half-up rounding term
    localparam logic [29:0] BASE_RND    = 30'd75000005;
    localparam logic [29:0] SPAN_HI     = DAY_TENTHS - BASE_RND;
    localparam logic [19:0] TENTHS_PER_MIN = 20'd600000;

    // day count of 1900-01-06 relative to the 1600-03-01 based count
    localparam logic [16:0] BASE_DAY = 17'd109518;
    localparam logic [10:0] EPOCH_YEAR = 11'd1600;

    typedef struct packed {
        logic              ok;
        logic [DNUM_W-1:0] day_num;
        logic [YOFS_W-1:0] year_ofs;
    } date_info_t;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days from march 1 to the first of the month, year starting in march
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] ofs;
        case (month)
            4'd3:    ofs = 9'd0;
            4'd4:    ofs = 9'd31;
            4'd5:    ofs = 9'd61;
            4'd6:    ofs = 9'd92;
            4'd7:    ofs = 9'd122;
            4'd8:    ofs = 9'd153;
            4'd9:    ofs = 9'd184;
            4'd10:   ofs = 9'd214;
            4'd11:   ofs = 9'd245;
            4'd12:   ofs = 9'd275;
            4'd1:    ofs = 9'd306;
            4'd2:    ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

    // term offset from the yearly base instant, in tenths of a millisecond
    function automatic logic [38:0] term_tenths(input logic [TERM_W-1:0] idx);
        logic [18:0] mins;
        case (idx)
            5'd0:    mins = 19'd0;
            5'd1:    mins = 19'd21208;
            5'd2:    mins = 19'd42467;
            5'd3:    mins = 19'd63836;
            5'd4:    mins = 19'd85337;
            5'd5:    mins = 19'd107014;
            5'd6:    mins = 19'd128867;
            5'd7:    mins = 19'd150921;
            5'd8:    mins = 19'd173149;
            5'd9:    mins = 19'd195551;
            5'd10:   mins = 19'd218072;
            5'd11:   mins = 19'd240693;
            5'd12:   mins = 19'd263343;
            5'd13:   mins = 19'd285989;
            5'd14:   mins = 19'd308563;
            5'd15:   mins = 19'd331033;
            5'd16:   mins = 19'd353350;
            5'd17:   mins = 19'd375494;
            5'd18:   mins = 19'd397447;
            5'd19:   mins = 19'd419210;
            5'd20:   mins = 19'd440795;
            5'd21:   mins = 19'd462224;
            5'd22:   mins = 19'd483532;
            5'd23:   mins = 19'd504758;
            default: mins = 19'd0;
        endcase
        return 39'(mins) * 39'(TENTHS_PER_MIN);
    endfunction

endpackage

[src/stdm_in_if.sv]
// ----------------------------------------------------------------------------
// stdm_in_if
// date channel: valid/ready handshake carrying one calendar date per item
// ----------------------------------------------------------------------------
interface stdm_in_if;
    import stdm_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  calendar_year;
    logic [MONTH_W-1:0] calendar_month;
    logic [DAY_W-1:0]   calendar_day;

    modport source (
        output valid,
        output calendar_year,
        output calendar_month,
        output calendar_day,
        input  ready
    );

    modport sink (
        input  valid,
        input  calendar_year,
        input  calendar_month,
        input  calendar_day,
        output ready
    );
endinterface

[src/stdm_out_if.sv]
// ----------------------------------------------------------------------------
// stdm_out_if
// term channel: valid/ready handshake carrying one lookup result per item
// ----------------------------------------------------------------------------
interface stdm_out_if;
    import stdm_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_term_day;
    logic [TERM_W-1:0] term_index;

    modport source (
        output valid,
        output is_term_day,
        output term_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  is_term_day,
        input  term_index,
        output ready
    );
endinterface

[src/solar_term_date_match.sv]
// ----------------------------------------------------------------------------
// solar_term_date_match
// reports whether a Gregorian date carries one of the 24 solar terms
// ----------------------------------------------------------------------------
// date_in takes one date per item (year, month, day); term_out returns one
// item per date: is_term_day and term_index (0 = minor cold .. 23 = winter
// solstice, 0 when no term). Dates outside 1900..2100 or not valid give no
// term. Results leave in the order the dates came in.
// The datapath is five register stages: date check and day count, the two
// products day*day_length and years*tropical_year, their difference, 24
// window compares, then the priority pick into the output register. One date
// is taken every cycle unless the stages are full and term_out stalls; the
// 47-bit product stage is fully pipelined.
// Each stage has its own valid bit and loads when it is empty or its
// successor moves, so a stalled receiver backs items up stage by stage and
// date_in.ready falls only once all five stages hold an item; no item is
// lost or repeated. Reset clears all valid bits, the block comes up empty.
// ----------------------------------------------------------------------------
module solar_term_date_match (
    input  logic       clk,
    input  logic       rst_n,
    stdm_in_if.sink    date_in,
    stdm_out_if.source term_out
);
    import stdm_pkg::*;

    date_info_t info;

    logic              s1_valid_reg;
    date_info_t        s1_info_reg;
    logic              s2_valid_reg;
    logic              s2_ok_reg;
    logic [PROD_W-1:0] s2_day_prod_reg;
    logic [PROD_W-1:0] s2_year_prod_reg;
    logic              s3_valid_reg;
    logic              s3_ok_reg;
    logic signed [DIFF_W-1:0] s3_lo_reg;
    logic signed [DIFF_W-1:0] s3_hi_reg;
    logic                  s4_valid_reg;
    logic [TERM_COUNT-1:0] s4_match_reg;
    logic              out_valid_reg;
    logic              out_term_reg;
    logic [TERM_W-1:0] out_index_reg;

    logic              out_adv;
    logic              s4_adv;
    logic              s3_adv;
    logic              s2_adv;
    logic              s1_adv;

    logic [PROD_W-1:0] day_prod_next;
    logic [PROD_W-1:0] year_prod_next;
    logic signed [DIFF_W-1:0] lo_next;
    logic signed [DIFF_W-1:0] hi_next;
    logic [TERM_COUNT-1:0] match_next;
    logic              term_next;
    logic [TERM_W-1:0] index_next;

    stdm_day_count u_day_count (
        .calendar_year  (date_in.calendar_year),
        .calendar_month (date_in.calendar_month),
        .calendar_day   (date_in.calendar_day),
        .info           (info)
    );

    // a stage loads when it is empty or its contents move on
    assign out_adv = !out_valid_reg || term_out.ready;
    assign s4_adv  = !s4_valid_reg || out_adv;
    assign s3_adv  = !s3_valid_reg || s4_adv;
    assign s2_adv  = !s2_valid_reg || s3_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;

    assign date_in.ready        = s1_adv;
    assign term_out.valid       = out_valid_reg;
    assign term_out.is_term_day = out_term_reg;
    assign term_out.term_index  = out_index_reg;

    always_comb
    begin
        day_prod_next  = PROD_W'(s1_info_reg.day_num) * PROD_W'(DAY_TENTHS);
        year_prod_next = PROD_W'(s1_info_reg.year_ofs) * PROD_W'(YEAR_TENTHS);

        // term i falls on the day when lo <= offset_i < hi
        lo_next = $signed({1'b0, s2_day_prod_reg}) - $signed({1'b0, s2_year_prod_reg})
                  - $signed(DIFF_W'(BASE_RND));
        hi_next = $signed({1'b0, s2_day_prod_reg}) - $signed({1'b0, s2_year_prod_reg})
                  + $signed(DIFF_W'(SPAN_HI));

        for (int i = 0; i < TERM_COUNT; i++)
        begin
            match_next[i] = s3_ok_reg
                && ($signed(DIFF_W'(term_tenths(TERM_W'(i)))) >= s3_lo_reg)
                && ($signed(DIFF_W'(term_tenths(TERM_W'(i)))) < s3_hi_reg);
        end

        // lowest term number wins
        term_next  = |s4_match_reg;
        index_next = '0;
        for (int i = TERM_COUNT - 1; i >= 0; i--)
        begin
            if (s4_match_reg[i])
            begin
                index_next = TERM_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= date_in.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_adv)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_info_reg <= info;
        end
        if (s2_adv)
        begin
            s2_ok_reg        <= s1_info_reg.ok;
            s2_day_prod_reg  <= day_prod_next;
            s2_year_prod_reg <= year_prod_next;
        end
        if (s3_adv)
        begin
            s3_ok_reg <= s2_ok_reg;
            s3_lo_reg <= lo_next;
            s3_hi_reg <= hi_next;
        end
        if (s4_adv)
        begin
            s4_match_reg <= match_next;
        end
        if (out_adv)
        begin
            out_term_reg  <= term_next;
            out_index_reg <= index_next;
        end
    end

endmodule

[src/stdm_day_count.sv]
// ----------------------------------------------------------------------------
// stdm_day_count
// checks a calendar date and turns it into days since 1900-01-06
// ----------------------------------------------------------------------------
module stdm_day_count (
    input  logic [stdm_pkg::YEAR_W-1:0]  calendar_year,
    input  logic [stdm_pkg::MONTH_W-1:0] calendar_month,
    input  logic [stdm_pkg::DAY_W-1:0]   calendar_day,
    output stdm_pkg::date_info_t         info
);
    import stdm_pkg::*;

    logic        year_ok;
    logic        month_ok;
    logic        is_leap;
    logic [4:0]  limit;
    logic        jan_feb;
    logic [8:0]  q;
    logic [13:0] q_wide;
    logic [14:0] q_x41;
    logic [2:0]  q_cent;
    logic        q_quad;
    logic [18:0] days_q;
    logic [19:0] count;
    logic        not_before;

    always_comb
    begin
        year_ok  = (calendar_year >= FIRST_YEAR) && (calendar_year <= LAST_YEAR);
        month_ok = (calendar_month >= MONTH_JAN) && (calendar_month <= MONTH_DEC);
        // inside the year window only 1900 and 2100 break the four-year rule
        is_leap  = (calendar_year[1:0] == 2'b00) && (calendar_year != FIRST_YEAR)
                   && (calendar_year != LAST_YEAR);
        limit    = month_len(calendar_month);
        if ((calendar_month == MONTH_FEB) && is_leap)
        begin
            limit = 5'd29;
        end

        // march-based year, counted from 1600 so the century terms stay small
        jan_feb = (calendar_month <= MONTH_FEB);
        q_wide  = calendar_year - 14'(EPOCH_YEAR) - 14'(jan_feb);
        q       = q_wide[8:0];
        q_x41   = 15'(q) * 15'd41;
        q_cent  = q_x41[14:12];               // q / 100 for q below 512
        q_quad  = (q >= 9'd400);
        days_q  = 19'(q) * 19'd365 + 19'(q[8:2]) - 19'(q_cent) + 19'(q_quad);

        count      = 20'(days_q) + 20'(month_start(calendar_month))
                     + 20'(calendar_day) - 20'd1;
        not_before = (count >= 20'(BASE_DAY));

        info.ok       = year_ok && month_ok && (calendar_day != 5'd0)
                        && (calendar_day <= limit) && not_before;
        info.day_num  = DNUM_W'(count - 20'(BASE_DAY));
        info.year_ofs = YOFS_W'(calendar_year - FIRST_YEAR);
    end

endmodule

[src/stdm_checker.sv]
// ----------------------------------------------------------------------------
// stdm_checker
// port-level checks on the term channel of the solar term date matcher
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stdm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        is_term_day,
    input logic [stdm_pkg::TERM_W-1:0] term_index
);
    import stdm_pkg::*;

    // a waiting item keeps its fields
    `STDM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(is_term_day) && $stable(term_index), "term_out changed while stalled")

    // no term means index zero
    `STDM_ASSERT_NOW(a_idx_zero, clk, rst_n, out_valid && !is_term_day, term_index == '0, "term_index set without a term")

    // index stays within the term list
    `STDM_ASSERT_NOW(a_idx_range, clk, rst_n, out_valid && is_term_day, term_index < TERM_W'(TERM_COUNT), "term_index out of range")

endmodule

bind solar_term_date_match stdm_checker u_stdm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (term_out.valid),
    .out_ready   (term_out.ready),
    .is_term_day (term_out.is_term_day),
    .term_index  (term_out.term_index)
);
